// ----- src/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// hte_pkg
// Types and constants shared by the static Huffman table encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int unsigned SYM_W     = 8;
    localparam int unsigned CODE_W    = 32;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PEND_W    = 7;
    localparam int unsigned PCNT_W    = 3;
    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned BCNT_W    = 3;
    localparam int unsigned ACC_W     = CODE_W + PEND_W;
    localparam int unsigned TOTAL_W   = 6;
    localparam int unsigned DEPTH     = 256;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out_item;

    // bytes produced by one item, lowest byte first
    typedef struct packed {
        logic [CODE_W-1:0] bytes;
        logic [BCNT_W-1:0] count;
    } t_pack_res;

endpackage

// ----- src/huffman_table_encoder_core.sv -----
// ----------------------------------------------------------------------------
// huffman_table_encoder_core
// Static Huffman encoder with a loadable 256-entry code table.
// ----------------------------------------------------------------------------
// An item is taken every cycle as long as the output register can absorb the
// bytes of the item ahead of it. An accepted encode passes the table read
// register and then the output register before its first output beat. An
// encode that completes k bytes (0 to 4) sends them as k output beats, so
// sustained rate is set by the one-byte-per-beat output port; loads, encodes
// that finish no byte and flushes of an empty byte do not wait on the output.
// Each beat's last_of_run marks the final byte of its item. No clearing pass
// after reset.
module huffman_table_encoder_core
    import hte_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = 32
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int unsigned LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic              in_acc;
    logic              wr_en;
    logic              rd_en;
    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W-1:0] tbl_code;
    logic [LEN_W-1:0]  tbl_len;
    logic              r_s1_vld;
    t_kind             r_s1_kind;
    t_pack_res         pack_res;
    logic              ob_free;
    logic              s1_adv;

    assign in_acc  = i_valid && o_ready;
    assign wr_en   = in_acc && (t_kind'(i_item.kind) == KIND_LOAD);
    assign rd_en   = in_acc && (t_kind'(i_item.kind) == KIND_ENCODE);
    assign len_sat = (i_item.code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM)
                                                            : i_item.code_length;

    // items with no bytes move on even while the output is busy
    assign s1_adv  = r_s1_vld && ((pack_res.count == '0) || ob_free);
    assign o_ready = !r_s1_vld || s1_adv;

    hte_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (i_item.symbol),
        .i_wr_code (i_item.code_word),
        .i_wr_len  (len_sat),
        .o_code    (tbl_code),
        .o_len     (tbl_len)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= t_kind'(i_item.kind);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    hte_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (r_s1_kind),
        .i_code  (tbl_code),
        .i_len   (tbl_len),
        .i_adv   (s1_adv),
        .o_res   (pack_res)
    );

    hte_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv && (pack_res.count != '0)),
        .i_res   (pack_res),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_free  (ob_free)
    );

endmodule

// ----- src/hte_table.sv -----
// ----------------------------------------------------------------------------
// hte_table
// Code and length tables, 256 entries each, with registered read.
// Lengths read as zero until their entry is loaded.
// ----------------------------------------------------------------------------
module hte_table
    import hte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [SYM_W-1:0]  i_addr,
    input  logic [CODE_W-1:0] i_wr_code,
    input  logic [LEN_W-1:0]  i_wr_len,
    output logic [CODE_W-1:0] o_code,
    output logic [LEN_W-1:0]  o_len
);

    logic [CODE_W-1:0] r_code_mem [DEPTH];
    logic [LEN_W-1:0]  r_len_mem  [DEPTH];
    logic [DEPTH-1:0]  r_len_vld;
    logic [CODE_W-1:0] r_code_rd;
    logic [LEN_W-1:0]  r_len_rd;
    logic              r_vld_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_code_mem[i_addr] <= i_wr_code;
            r_len_mem[i_addr]  <= i_wr_len;
        end
        if (i_rd_en) begin
            r_code_rd <= r_code_mem[i_addr];
            r_len_rd  <= r_len_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_vld_rd  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_len_vld[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_rd <= r_len_vld[i_addr];
            end
        end
    end

    assign o_code = r_code_rd;
    assign o_len  = r_vld_rd ? r_len_rd : '0;

endmodule

// ----- src/hte_pack.sv -----
// ----------------------------------------------------------------------------
// hte_pack
// Bit packer: merges a code with the pending partial byte, splits off the
// full bytes and keeps the leftover bits.
// ----------------------------------------------------------------------------
module hte_pack
    import hte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kind             i_kind,
    input  logic [CODE_W-1:0] i_code,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_adv,
    output t_pack_res         o_res
);

    logic [PEND_W-1:0]  r_pbits, n_pbits;
    logic [PCNT_W-1:0]  r_pcnt, n_pcnt;
    logic [CODE_W-1:0]  code_m;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   acc_rem;
    logic [TOTAL_W-1:0] total;
    logic [BCNT_W-1:0]  nbytes;

    // lengths never exceed CODE_W, so a shift by CODE_W keeps every bit
    assign code_m  = i_code & ~({CODE_W{1'b1}} << i_len);
    assign acc     = {{CODE_W{1'b0}}, r_pbits}
                   | ({{PEND_W{1'b0}}, code_m} << r_pcnt);
    assign total   = TOTAL_W'(r_pcnt) + TOTAL_W'(i_len);
    assign nbytes  = total[TOTAL_W-1:3];
    assign acc_rem = acc >> {nbytes, 3'b000};

    always_comb begin
        o_res   = '0;
        n_pbits = r_pbits;
        n_pcnt  = r_pcnt;
        case (i_kind)
            KIND_ENCODE: begin
                o_res.bytes = acc[CODE_W-1:0];
                o_res.count = nbytes;
                n_pbits     = acc_rem[PEND_W-1:0];
                n_pcnt      = total[PCNT_W-1:0];
            end
            KIND_FLUSH: begin
                o_res.bytes = {{(CODE_W-PEND_W){1'b0}}, r_pbits};
                o_res.count = (r_pcnt != '0) ? BCNT_W'(1) : '0;
                n_pbits     = '0;
                n_pcnt      = '0;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
        end else if (i_adv) begin
            r_pbits <= n_pbits;
            r_pcnt  <= n_pcnt;
        end
    end

endmodule

// ----- src/hte_outbuf.sv -----
// ----------------------------------------------------------------------------
// hte_outbuf
// Output register: holds the bytes of one item and sends one per beat.
// ----------------------------------------------------------------------------
module hte_outbuf
    import hte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_pack_res i_res,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_item o_data,
    output logic      o_free
);

    logic [CODE_W-1:0] r_data, n_data;
    logic [BCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    // free when empty or the final byte leaves this cycle
    assign o_free  = (r_cnt == '0) || (r_cnt == BCNT_W'(1) && i_ready);

    assign o_data.out_byte    = r_data[BYTE_W-1:0];
    assign o_data.last_of_run = (r_cnt == BCNT_W'(1));

    always_comb begin
        n_data = r_data;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_data = i_res.bytes;
            n_cnt  = i_res.count;
        end else if (pop) begin
            n_data = r_data >> BYTE_W;
            n_cnt  = r_cnt - BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- src/hte_checker.sv -----
// ----------------------------------------------------------------------------
// hte_checker
// Port-level checks for the Huffman table encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hte_checker
    import hte_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // an offered input beat stays put until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_item))
        else $error("input beat changed while stalled");

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // nothing shows right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // bytes of one item come back to back until the last one
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_of_run |=> o_valid)
        else $error("run ended without last_of_run");

    // with the output empty the input side is never blocked
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output empty");

endmodule

bind huffman_table_encoder_core hte_checker u_hte_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ----- dv/huffman_table_encoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// huffman_table_encoder_core_tb
// Self-checking bench for the static Huffman table encoder. Loads, encodes,
// flushes and ignored kinds are sent with random gaps and output stalls. A
// scoreboard keeps its own code table and pending byte, predicts every packed
// byte, and compares each output beat against it in order.
// ----------------------------------------------------------------------------
module huffman_table_encoder_core_tb
    import hte_pkg::*;
;

    localparam int unsigned MAX_CODE_LEN   = 32;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned TIMEOUT_CYCLES = 300000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned RAND_ITEMS     = 420;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;

    // symbols whose table entry has been written at least once
    bit         sym_loaded [DEPTH];
    logic [7:0] loaded_syms [$];

    class pack_scoreboard;
        logic [CODE_W-1:0] code_tab [DEPTH];
        logic [LEN_W-1:0]  len_tab [DEPTH];
        logic [PEND_W-1:0] pend_bits;
        logic [PCNT_W-1:0] pend_cnt;
        t_out_item         expected_bytes [$];
        int unsigned       errors;
        int unsigned       bytes_checked;
        int unsigned       kind_count [4];

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                code_tab[i] = '0;
                len_tab[i]  = '0;
            end
            pend_bits = '0;
            pend_cnt  = '0;
            errors = 0;
            bytes_checked = 0;
            for (int i = 0; i < 4; i++) kind_count[i] = 0;
        endfunction

        function void note_item(t_in_item it);
            int unsigned       lim;
            int unsigned       clen;
            int unsigned       total;
            logic [CODE_W-1:0] code;
            logic [ACC_W-1:0]  acc;
            t_out_item         b;
            kind_count[it.kind]++;
            lim = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
            case (it.kind)
                KIND_LOAD: begin
                    code_tab[it.symbol] = it.code_word;
                    len_tab[it.symbol]  = (it.code_length > lim) ? LEN_W'(lim) : it.code_length;
                end
                KIND_ENCODE: begin
                    clen = len_tab[it.symbol];
                    code = code_tab[it.symbol];
                    if (clen < CODE_W)
                        code = code & ((CODE_W'(1) << clen) - CODE_W'(1));
                    acc   = ACC_W'(pend_bits) | (ACC_W'(code) << pend_cnt);
                    total = pend_cnt + clen;
                    while (total >= 8) begin
                        b.out_byte    = acc[7:0];
                        b.last_of_run = (total < 16);
                        expected_bytes.push_back(b);
                        acc   = acc >> 8;
                        total = total - 8;
                    end
                    pend_cnt  = PCNT_W'(total);
                    pend_bits = acc[PEND_W-1:0];
                end
                KIND_FLUSH: begin
                    if (pend_cnt != 0) begin
                        b.out_byte    = {1'b0, pend_bits};
                        b.last_of_run = 1'b1;
                        expected_bytes.push_back(b);
                    end
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
                default: ;
            endcase
        endfunction

        function void check_byte(t_out_item got);
            t_out_item exp_b;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output beat: out_byte=%02h last_of_run=%0b",
                       got.out_byte, got.last_of_run);
                errors++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            bytes_checked++;
            if (got.out_byte !== exp_b.out_byte) begin
                $error("out_byte mismatch: expected %02h, got %02h",
                       exp_b.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_of_run !== exp_b.last_of_run) begin
                $error("last_of_run mismatch: expected %0b, got %0b",
                       exp_b.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    pack_scoreboard sb = new();

    huffman_table_encoder_core #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic t_in_item mk_item(logic [1:0] kind, logic [7:0] sym,
                                         logic [31:0] word, logic [5:0] len);
        t_in_item it;
        it.kind        = kind;
        it.symbol      = sym;
        it.code_word   = word;
        it.code_length = len;
        return it;
    endfunction

    // offer one beat, after a random gap if tx_idle is set, and hold it until accepted
    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
        if (it.kind == KIND_LOAD && !sym_loaded[it.symbol]) begin
            sym_loaded[it.symbol] = 1'b1;
            loaded_syms.push_back(it.symbol);
        end
    endtask

    // sender stops until every predicted byte has come out
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_bytes.size() != 0);
    endtask

    function automatic logic [5:0] rand_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)      return 6'($urandom_range(1, 12));
        else if (sel < 75) return 6'($urandom_range(13, 32));
        else if (sel < 85) return 6'd0;
        else               return 6'($urandom_range(33, 63));
    endfunction

    function automatic t_in_item rand_item();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15 || loaded_syms.size() == 0)
            return mk_item(KIND_LOAD, 8'($urandom_range(0, 255)), $urandom, rand_length());
        else if (sel < 86)
            return mk_item(KIND_ENCODE,
                           loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                           $urandom, 6'($urandom_range(0, 63)));
        else if (sel < 96)
            return mk_item(KIND_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                           6'($urandom_range(0, 63)));
        else
            return mk_item(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                           6'($urandom_range(0, 63)));
    endfunction

    // output side: random stall after each beat while rx_idle is set, plus one long hold on request
    initial begin : rx_proc
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_byte(o_data);
                stall = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("huffman_table_encoder_core_tb NOT OK");
        $finish;
    end

    initial begin : main_seq
        t_in_item    directed [$];
        t_in_item    it;
        int unsigned counted;
        for (int i = 0; i < DEPTH; i++) sym_loaded[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-ones full-length code, zero code with overlong length
        directed.push_back(mk_item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
        directed.push_back(mk_item(KIND_LOAD, 8'hFF, 32'h0000_0000, 6'd63));
        directed.push_back(mk_item(KIND_LOAD, 8'h01, 32'hFFFF_FFF5, 6'd3));
        directed.push_back(mk_item(KIND_LOAD, 8'h02, 32'hAAAA_AAAB, 6'd1));
        // written entry with zero length behaves as unloaded
        directed.push_back(mk_item(KIND_LOAD, 8'h03, 32'h1234_5678, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h03, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
        directed.push_back(mk_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));
        // build up 7 pending bits, then a 32-bit code: four bytes
        directed.push_back(mk_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h01, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
        directed.push_back(mk_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_LOAD, 8'h80, 32'h8000_007F, 6'd7));
        directed.push_back(mk_item(KIND_ENCODE, 8'h80, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h80, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_ENCODE, 8'h02, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));
        directed.push_back(mk_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0));
        // symbol never loaded: length reads zero, nothing comes out
        directed.push_back(mk_item(KIND_ENCODE, 8'h55, 32'h0, 6'd0));

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        foreach (directed[i]) begin
            if (i == 12) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            send_item(directed[i]);
        end

        counted = 0;
        while (counted < RAND_ITEMS) begin
            if (counted % 64 == 0) begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            if (counted == 150) begin
                // long output stall while input keeps coming back to back
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            if (counted == 300)
                pause_until_drained();
            it = rand_item();
            send_item(it);
            if (it.kind != KIND_UNUSED)
                counted++;
        end
        i_valid <= 1'b0;

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d loads, %0d encodes, %0d flushes, %0d unused-kind beats",
                 sb.kind_count[KIND_LOAD], sb.kind_count[KIND_ENCODE],
                 sb.kind_count[KIND_FLUSH], sb.kind_count[KIND_UNUSED]);
        $display("checked %0d output bytes, %0d table entries touched, %0d errors",
                 sb.bytes_checked, loaded_syms.size(), sb.errors);
        if (sb.errors == 0) begin
            $display("huffman_table_encoder_core_tb OK");
        end else begin
            $display("huffman_table_encoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/hte_pkg.sv
src/hte_table.sv
src/hte_pack.sv
src/hte_outbuf.sv
src/huffman_table_encoder_core.sv
src/hte_checker.sv
dv/huffman_table_encoder_core_tb.sv
